>>> rtl/ttbl_pkg.sv
package ttbl_pkg;

    localparam int KEY_W   = 64;
    localparam int WORD_W  = 16;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int REQ_W   = 4;
    localparam int STAT_W  = 3;
    localparam int IN_W    = 104;
    localparam int OUT_W   = 128;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD    = 4'd0,
        REQ_FIND    = 4'd1,
        REQ_ADD     = 4'd2,
        REQ_REMOVE  = 4'd3,
        REQ_HIDE    = 4'd4,
        REQ_SHOW    = 4'd5,
        REQ_CLEAR   = 4'd6,
        REQ_COMPACT = 4'd7,
        REQ_READ    = 4'd8
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STS_OK         = 3'd0,
        STS_NOT_FOUND  = 3'd1,
        STS_PRESENT    = 3'd2,
        STS_HIDDEN     = 3'd3,
        STS_NOT_HIDDEN = 3'd4,
        STS_FULL       = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMPACT,
        ST_CLEAR,
        ST_READ,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic compact;
        logic clear;
        logic read_idx;
        logic apply;
    } cmd_t;

    typedef struct packed {
        logic found;
        logic pass_end;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/ttbl_ctrl.sv
module ttbl_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  ttbl_pkg::req_t  in_op,
    input  ttbl_pkg::stat_t stat,
    output logic            s_tready,
    output ttbl_pkg::cmd_t  cmd
);

    ttbl_pkg::state_t state_reg;
    ttbl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttbl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ttbl_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    priority case (in_op)
                        ttbl_pkg::REQ_FIND, ttbl_pkg::REQ_ADD, ttbl_pkg::REQ_REMOVE,
                        ttbl_pkg::REQ_HIDE, ttbl_pkg::REQ_SHOW:
                            state_next = ttbl_pkg::ST_SCAN;
                        ttbl_pkg::REQ_COMPACT: state_next = ttbl_pkg::ST_COMPACT;
                        ttbl_pkg::REQ_CLEAR:   state_next = ttbl_pkg::ST_CLEAR;
                        ttbl_pkg::REQ_READ:    state_next = ttbl_pkg::ST_READ;
                        default:               state_next = ttbl_pkg::ST_APPLY;
                    endcase
                end
            end
            ttbl_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.found || stat.pass_end)
                begin
                    state_next = ttbl_pkg::ST_APPLY;
                end
            end
            ttbl_pkg::ST_COMPACT:
            begin
                cmd.compact = 1'b1;
                if (stat.pass_end)
                begin
                    state_next = ttbl_pkg::ST_APPLY;
                end
            end
            ttbl_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.pass_end)
                begin
                    state_next = ttbl_pkg::ST_APPLY;
                end
            end
            ttbl_pkg::ST_READ:
            begin
                cmd.read_idx = 1'b1;
                state_next   = ttbl_pkg::ST_APPLY;
            end
            ttbl_pkg::ST_APPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.apply  = 1'b1;
                    state_next = ttbl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttbl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/ttbl_datapath.sv
module ttbl_datapath #(
    parameter int TABLE_SLOTS = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ttbl_pkg::cmd_t             cmd,
    input  ttbl_pkg::req_t             in_op,
    input  logic [ttbl_pkg::IN_W-1:0]  in_data,
    input  logic                       m_tready,
    output ttbl_pkg::stat_t            stat,
    output logic                       m_tvalid,
    output logic [ttbl_pkg::OUT_W-1:0] m_tdata
);

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);

    logic [ttbl_pkg::KEY_W-1:0]  key_mem   [TABLE_SLOTS];
    logic [ttbl_pkg::WORD_W-1:0] stash_mem [TABLE_SLOTS];
    logic [ttbl_pkg::WORD_W-1:0] user_mem  [TABLE_SLOTS];

    logic [ttbl_pkg::KEY_W-1:0]  rd_key_reg;
    logic [ttbl_pkg::WORD_W-1:0] rd_stash_reg;
    logic [ttbl_pkg::WORD_W-1:0] rd_user_reg;

    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [ttbl_pkg::KEY_W-1:0]  wr_key;
    logic [ttbl_pkg::WORD_W-1:0] wr_stash;
    logic [ttbl_pkg::WORD_W-1:0] wr_user;

    ttbl_pkg::req_t              op_reg, op_next;
    logic [ttbl_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [ttbl_pkg::WORD_W-1:0] ls_reg, ls_next;
    logic [ttbl_pkg::WORD_W-1:0] lu_reg, lu_next;
    logic [ttbl_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [CW-1:0]               addr_reg, addr_next;
    logic                        chk_v_reg, chk_v_next;
    logic [AW-1:0]               chk_idx_reg, chk_idx_next;
    logic                        found_reg, found_next;
    logic [AW-1:0]               fidx_reg, fidx_next;
    logic [ttbl_pkg::KEY_W-1:0]  fkey_reg, fkey_next;
    logic [ttbl_pkg::WORD_W-1:0] fstash_reg, fstash_next;
    logic [ttbl_pkg::WORD_W-1:0] fuser_reg, fuser_next;
    logic                        zfound_reg, zfound_next;
    logic [AW-1:0]               zidx_reg, zidx_next;
    logic [CW-1:0]               j_reg, j_next;
    logic [CW-1:0]               used_reg, used_next;
    logic [CW-1:0]               live_reg, live_next;
    logic [CW-1:0]               hid_reg, hid_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [ttbl_pkg::OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [ttbl_pkg::KEY_W-1:0]  visible;
    logic [CW-1:0]               jp1;
    ttbl_pkg::status_t           st;
    logic [ttbl_pkg::IDX_W-1:0]  pos;
    logic                        hnow;
    logic [ttbl_pkg::KEY_W-1:0]  okey;
    logic [ttbl_pkg::WORD_W-1:0] ostash;
    logic [ttbl_pkg::WORD_W-1:0] ouser;
    logic                        old_l, old_h, new_l, new_h;

    // table storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= wr_key;
            stash_mem[wr_addr] <= wr_stash;
            user_mem[wr_addr]  <= wr_user;
        end
        if (rd_en)
        begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_stash_reg <= stash_mem[rd_addr];
            rd_user_reg  <= user_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_v_reg    <= 1'b0;
            found_reg    <= 1'b0;
            zfound_reg   <= 1'b0;
            used_reg     <= '0;
            live_reg     <= '0;
            hid_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            chk_v_reg    <= chk_v_next;
            found_reg    <= found_next;
            zfound_reg   <= zfound_next;
            used_reg     <= used_next;
            live_reg     <= live_next;
            hid_reg      <= hid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        ls_reg      <= ls_next;
        lu_reg      <= lu_next;
        idx_reg     <= idx_next;
        addr_reg    <= addr_next;
        chk_idx_reg <= chk_idx_next;
        fidx_reg    <= fidx_next;
        fkey_reg    <= fkey_next;
        fstash_reg  <= fstash_next;
        fuser_reg   <= fuser_next;
        zidx_reg    <= zidx_next;
        j_reg       <= j_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign visible = (rd_stash_reg == '0) ? rd_key_reg : {rd_stash_reg, rd_key_reg[47:0]};
    assign jp1     = j_reg + CW'(1);

    always_comb
    begin
        op_next       = op_reg;
        key_next      = key_reg;
        ls_next       = ls_reg;
        lu_next       = lu_reg;
        idx_next      = idx_reg;
        addr_next     = addr_reg;
        chk_v_next    = chk_v_reg;
        chk_idx_next  = chk_idx_reg;
        found_next    = found_reg;
        fidx_next     = fidx_reg;
        fkey_next     = fkey_reg;
        fstash_next   = fstash_reg;
        fuser_next    = fuser_reg;
        zfound_next   = zfound_reg;
        zidx_next     = zidx_reg;
        j_next        = j_reg;
        used_next     = used_reg;
        live_next     = live_reg;
        hid_next      = hid_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        rd_en         = 1'b0;
        rd_addr       = addr_reg[AW-1:0];
        wr_en         = 1'b0;
        wr_addr       = addr_reg[AW-1:0];
        wr_key        = '0;
        wr_stash      = '0;
        wr_user       = '0;
        st            = ttbl_pkg::STS_OK;
        pos           = '0;
        hnow          = 1'b0;
        okey          = '0;
        ostash        = '0;
        ouser         = '0;
        old_l         = 1'b0;
        old_h         = 1'b0;
        new_l         = 1'b0;
        new_h         = 1'b0;

        if (cmd.capture)
        begin
            op_next     = in_op;
            key_next    = in_data[63:0];
            ls_next     = in_data[79:64];
            lu_next     = in_data[95:80];
            idx_next    = in_data[101:96];
            addr_next   = '0;
            chk_v_next  = 1'b0;
            found_next  = 1'b0;
            zfound_next = 1'b0;
            j_next      = '0;
        end

        // pipelined pass: read one slot per cycle, check it the cycle after
        if (cmd.scan || cmd.compact)
        begin
            if (addr_reg < used_reg)
            begin
                rd_en        = 1'b1;
                addr_next    = addr_reg + CW'(1);
                chk_v_next   = 1'b1;
                chk_idx_next = addr_reg[AW-1:0];
            end
            else
            begin
                chk_v_next = 1'b0;
            end
        end

        if (cmd.scan && chk_v_reg && !found_reg)
        begin
            if (visible == key_reg)
            begin
                found_next  = 1'b1;
                fidx_next   = chk_idx_reg;
                fkey_next   = rd_key_reg;
                fstash_next = rd_stash_reg;
                fuser_next  = rd_user_reg;
            end
            if (rd_key_reg == '0 && !zfound_reg)
            begin
                zfound_next = 1'b1;
                zidx_next   = chk_idx_reg;
            end
        end

        if (cmd.compact && chk_v_reg && rd_key_reg != '0)
        begin
            wr_en    = 1'b1;
            wr_addr  = j_reg[AW-1:0];
            wr_key   = rd_key_reg;
            wr_stash = rd_stash_reg;
            wr_user  = ttbl_pkg::WORD_W'(jp1);
            j_next   = jp1;
        end

        if (cmd.clear && addr_reg < used_reg)
        begin
            wr_en     = 1'b1;
            addr_next = addr_reg + CW'(1);
        end

        if (cmd.read_idx)
        begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_reg);
        end

        if (cmd.apply)
        begin
            priority case (op_reg)
                ttbl_pkg::REQ_LOAD:
                begin
                    if (used_reg >= SLOTS_C)
                    begin
                        st = ttbl_pkg::STS_FULL;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = used_reg[AW-1:0];
                        wr_key    = key_reg;
                        wr_stash  = ls_reg;
                        wr_user   = lu_reg;
                        pos       = ttbl_pkg::IDX_W'(used_reg);
                        used_next = used_reg + CW'(1);
                        new_l     = key_reg != '0;
                        new_h     = new_l && ls_reg != '0;
                        hnow      = key_reg[63:48] == '0 && ls_reg != '0;
                    end
                end
                ttbl_pkg::REQ_FIND:
                begin
                    if (!found_reg)
                    begin
                        st = ttbl_pkg::STS_NOT_FOUND;
                    end
                    else
                    begin
                        pos  = ttbl_pkg::IDX_W'(fidx_reg);
                        hnow = fkey_reg[63:48] == '0 && fstash_reg != '0;
                    end
                end
                ttbl_pkg::REQ_ADD:
                begin
                    if (found_reg)
                    begin
                        st = ttbl_pkg::STS_PRESENT;
                    end
                    else if (zfound_reg || used_reg < SLOTS_C)
                    begin
                        wr_en  = 1'b1;
                        wr_key = key_reg;
                        if (zfound_reg)
                        begin
                            wr_addr = zidx_reg;
                        end
                        else
                        begin
                            wr_addr   = used_reg[AW-1:0];
                            used_next = used_reg + CW'(1);
                        end
                        pos   = ttbl_pkg::IDX_W'(wr_addr);
                        new_l = key_reg != '0;
                    end
                    else
                    begin
                        st = ttbl_pkg::STS_FULL;
                    end
                end
                ttbl_pkg::REQ_REMOVE:
                begin
                    if (!found_reg)
                    begin
                        st = ttbl_pkg::STS_NOT_FOUND;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = fidx_reg;
                        pos     = ttbl_pkg::IDX_W'(fidx_reg);
                        old_l   = fkey_reg != '0;
                        old_h   = old_l && fstash_reg != '0;
                    end
                end
                ttbl_pkg::REQ_HIDE:
                begin
                    if (!found_reg)
                    begin
                        st = ttbl_pkg::STS_NOT_FOUND;
                    end
                    else if (fstash_reg != '0)
                    begin
                        st = ttbl_pkg::STS_HIDDEN;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = fidx_reg;
                        wr_key   = {16'h0000, fkey_reg[47:0]};
                        wr_stash = fkey_reg[63:48];
                        wr_user  = fuser_reg;
                        pos      = ttbl_pkg::IDX_W'(fidx_reg);
                        old_l    = fkey_reg != '0;
                        new_l    = fkey_reg[47:0] != '0;
                        new_h    = new_l && fkey_reg[63:48] != '0;
                        hnow     = fkey_reg[63:48] != '0;
                    end
                end
                ttbl_pkg::REQ_SHOW:
                begin
                    if (!found_reg)
                    begin
                        st = ttbl_pkg::STS_NOT_FOUND;
                    end
                    else if (fstash_reg == '0)
                    begin
                        st = ttbl_pkg::STS_NOT_HIDDEN;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = fidx_reg;
                        wr_key  = {fstash_reg, fkey_reg[47:0]};
                        wr_user = fuser_reg;
                        pos     = ttbl_pkg::IDX_W'(fidx_reg);
                        old_l   = fkey_reg != '0;
                        old_h   = old_l;
                        new_l   = 1'b1;
                    end
                end
                ttbl_pkg::REQ_CLEAR:
                begin
                    live_next = '0;
                    hid_next  = '0;
                end
                ttbl_pkg::REQ_COMPACT:
                begin
                    used_next = j_reg;
                end
                ttbl_pkg::REQ_READ:
                begin
                    if (int'(idx_reg) >= int'(used_reg))
                    begin
                        st = ttbl_pkg::STS_NOT_FOUND;
                    end
                    else
                    begin
                        pos    = idx_reg;
                        okey   = rd_key_reg;
                        ostash = rd_stash_reg;
                        ouser  = rd_user_reg;
                        hnow   = rd_key_reg[63:48] == '0 && rd_stash_reg != '0;
                    end
                end
                default:
                begin
                end
            endcase

            if (op_reg != ttbl_pkg::REQ_CLEAR)
            begin
                live_next = live_reg - CW'(old_l) + CW'(new_l);
                hid_next  = hid_reg - CW'(old_h) + CW'(new_h);
            end

            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, ouser, ostash, okey,
                             ttbl_pkg::CNT_W'(used_next),
                             ttbl_pkg::CNT_W'(hid_next),
                             ttbl_pkg::CNT_W'(live_next),
                             hnow, pos, st};
        end
    end

    assign stat.found    = found_reg;
    assign stat.pass_end = (addr_reg >= used_reg) && !chk_v_reg;
    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= SLOTS_C)
        else $error("slot count beyond table size");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= used_reg)
        else $error("live count above slots in use");

    a_hid_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hid_reg <= live_reg)
        else $error("hidden count above live count");

    a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (CW'(fidx_reg) < used_reg))
        else $error("match outside slots in use");

endmodule

>>> rtl/title_uid_table_top.sv
// timing: find, add, remove, hide and show scan the slots in use up to a match,
// one slot per cycle through the table memory read port; compact and clear also
// pass over the slots in use, load and read do not; every result also waits until
// the previous result has been taken on m_tready
// throughput: one word at a time, the next accepted once the result is registered
// reset: rst_n async active low empties the table (no slots in use), no clearing pass
module title_uid_table_top #(
    parameter int TABLE_SLOTS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // key, load_stash, load_user, entry_index
    input  logic [3:0]   s_tuser,  // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata   // status, position, hidden_now, live_count,
                                   // hidden_count, entries_used, out_key,
                                   // out_stash, out_user
);

    ttbl_pkg::cmd_t  cmd;
    ttbl_pkg::stat_t stat;
    ttbl_pkg::req_t  in_op;

    assign in_op = ttbl_pkg::req_t'(s_tuser);

    ttbl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .in_op    (in_op),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    ttbl_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_op    (in_op),
        .in_data  (s_tdata),
        .m_tready (m_tready),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
